// ----- hdl/rdq_pkg.sv -----
// Package with the action and status codes and the record type of the record deque.
package rdq_pkg;

	localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [2:0] ACT_POP_BACK   = 3'd3;
	localparam logic [2:0] ACT_LIST       = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam int POS_W = 6;

	typedef struct packed {
		logic [63:0] name;
		logic signed [31:0] id;
	} rec_t;

endpackage

// ----- hdl/record_deque.sv -----
// Top level of the record deque: a bounded double-ended queue of records in a ring buffer.
//
// A command word enters on the s_ side: tuser carries the action, tdata the ID number
// and the packed name. Pushes and pops answer with one word on the m_ side; a list
// answers with one word per held record, front to back, with its position, and
// tlast marks the final word of each answer. Status travels in m_tuser.
// A push is answered in the cycle after it is accepted. A pop reads the memory into
// the store's read register and is answered from there through the output register.
// A list streams one record per cycle once its first read is done, as long as the
// receiver takes them. The memory's single read port sets that pace. Input is taken
// only while no answer is in progress and the output register is free or being emptied,
// so a push may be followed by the next command in the next cycle; a pop must first
// leave the streaming state. When the receiver stalls, the answer waits in the output
// register and listing pauses with it. Reset empties the store at once; the memory needs
// no clearing because only slots that hold records are ever read.
module record_deque
	import rdq_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [2:0]   s_tuser,  // action
	input  logic [95:0]  s_tdata,  // id_number [31:0], name_bytes [95:32]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [1:0]   m_tuser,  // status
	output logic [103:0] m_tdata,  // position [5:0], id_out [37:6], name_out [101:38], zero
	output logic         m_tlast
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic S_IDLE   = 1'b0;
	localparam logic S_STREAM = 1'b1;

	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
			input logic [CW-1:0] off);
		logic [IW+1:0] s;
		s = (IW+2)'(base) + (IW+2)'(off);
		if (s >= (IW+2)'(DEPTH)) begin
			s = s - (IW+2)'(DEPTH);
		end
		return s[IW-1:0];
	endfunction

	logic          state_q;
	logic [IW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] cursor_q;
	logic [CW-1:0] remain_q;
	logic          rd_valid_s1;
	logic [POS_W-1:0] pos_s1;
	logic          last_s1;

	logic          m_tvalid_q;
	logic [1:0]    status_q;
	logic [POS_W-1:0] pos_q;
	rec_t          rec_q;
	logic          last_q;

	logic          accept, out_free, is_full, is_empty, issue;
	logic [2:0]    action;
	logic [IW-1:0] front_prev;
	logic          wr_en, rd_en, load_out;
	logic [IW-1:0] wr_addr, rd_addr;
	rec_t          wr_data, rd_data;
	logic [1:0]    out_status;
	logic [POS_W-1:0] out_pos;
	rec_t          out_rec;
	logic          out_last;

	assign action     = s_tuser;
	assign out_free   = !m_tvalid_q || m_tready;
	assign s_tready   = (state_q == S_IDLE) && out_free;
	assign accept     = s_tvalid && s_tready;
	assign is_full    = count_q == CW'(DEPTH);
	assign is_empty   = count_q == '0;
	assign front_prev = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
	assign wr_data    = rec_t'(s_tdata);
	assign issue      = (state_q == S_STREAM) && (remain_q != '0) && (!rd_valid_s1 || out_free);

	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = front_prev;
		rd_en      = 1'b0;
		rd_addr    = cursor_q;
		load_out   = 1'b0;
		out_status = ST_OK;
		out_pos    = '0;
		out_rec    = '0;
		out_last   = 1'b1;
		if (state_q == S_IDLE) begin
			if (accept) begin
				unique case (action)
					ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
						load_out   = 1'b1;
						out_status = is_full ? ST_FULL : ST_OK;
						wr_en      = !is_full;
						wr_addr    = (action == ACT_PUSH_FRONT) ? front_prev
							: wrap_add(front_q, count_q);
					end
					ACT_POP_FRONT, ACT_POP_BACK: begin
						if (is_empty) begin
							load_out   = 1'b1;
							out_status = ST_EMPTY;
						end else begin
							rd_en   = 1'b1;
							rd_addr = (action == ACT_POP_FRONT) ? front_q
								: wrap_add(front_q, count_q - CW'(1));
						end
					end
					ACT_LIST: begin
						if (is_empty) begin
							load_out   = 1'b1;
							out_status = ST_EMPTY;
						end else begin
							rd_en   = 1'b1;
							rd_addr = front_q;
						end
					end
					default: begin
					end
				endcase
			end
		end else begin
			if (rd_valid_s1 && out_free) begin
				load_out = 1'b1;
				out_pos  = pos_s1;
				out_rec  = rd_data;
				out_last = last_s1;
			end
			rd_en   = issue;
			rd_addr = cursor_q;
		end
	end

	rdq_store #(
		.DEPTH (DEPTH),
		.IW    (IW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			cursor_q    <= '0;
			remain_q    <= '0;
			rd_valid_s1 <= 1'b0;
			pos_s1      <= '0;
			last_s1     <= 1'b0;
		end else if (state_q == S_IDLE) begin
			if (accept) begin
				unique case (action)
					ACT_PUSH_FRONT: begin
						if (!is_full) begin
							front_q <= front_prev;
							count_q <= count_q + CW'(1);
						end
					end
					ACT_PUSH_BACK: begin
						if (!is_full) begin
							count_q <= count_q + CW'(1);
						end
					end
					ACT_POP_FRONT, ACT_POP_BACK: begin
						if (!is_empty) begin
							if (action == ACT_POP_FRONT) begin
								front_q <= wrap_add(front_q, CW'(1));
							end
							count_q     <= count_q - CW'(1);
							rd_valid_s1 <= 1'b1;
							pos_s1      <= '0;
							last_s1     <= 1'b1;
							remain_q    <= '0;
							state_q     <= S_STREAM;
						end
					end
					ACT_LIST: begin
						if (!is_empty) begin
							rd_valid_s1 <= 1'b1;
							pos_s1      <= POS_W'(1);
							last_s1     <= count_q == CW'(1);
							remain_q    <= count_q - CW'(1);
							cursor_q    <= wrap_add(front_q, CW'(1));
							state_q     <= S_STREAM;
						end
					end
					default: begin
					end
				endcase
			end
		end else begin
			if (issue) begin
				rd_valid_s1 <= 1'b1;
				pos_s1      <= pos_s1 + POS_W'(1);
				last_s1     <= remain_q == CW'(1);
				remain_q    <= remain_q - CW'(1);
				cursor_q    <= wrap_add(cursor_q, CW'(1));
			end else if (load_out) begin
				rd_valid_s1 <= 1'b0;
			end
			if (!issue && remain_q == '0 && (!rd_valid_s1 || load_out)) begin
				state_q <= S_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= out_status;
			pos_q    <= out_pos;
			rec_q    <= out_rec;
			last_q   <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {2'b00, rec_q.name, rec_q.id, pos_q};
	assign m_tlast  = last_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("Record count exceeds the depth.");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= IW'(DEPTH - 1))
		else $error("Front slot lies outside the store.");

	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !rd_valid_s1 && remain_q == '0)
		else $error("Read pending while idle.");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (action == ACT_PUSH_FRONT || action == ACT_PUSH_BACK) && !is_full
		|=> count_q == $past(count_q) + CW'(1))
		else $error("Accepted push did not add a record.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> out_free)
		else $error("Output register loaded while still holding a word.");
`endif

endmodule

// ----- hdl/rdq_store.sv -----
// Record store: single-port-write, single-port-read memory with a registered read.
module rdq_store
	import rdq_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int IW    = 5
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  rec_t          wr_data,
	input  logic          rd_en,
	input  logic [IW-1:0] rd_addr,
	output rec_t          rd_data
);

	rec_t mem [DEPTH];
	rec_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
